// File: rtl/hsvrot_pkg.sv
// Shared types, constants and helpers for the HSV hue rotation pipeline.
package hsvrot_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned HueW  = 11;
  localparam int unsigned QuotW = PixW + 1;

  // Hue circle in 1/256 sextant units
  localparam logic [HueW-1:0] HueTurn      = 11'd1536;
  localparam logic [HueW-1:0] HueBaseRed   = 11'd0;
  localparam logic [HueW-1:0] HueBaseGreen = 11'd512;
  localparam logic [HueW-1:0] HueBaseBlue  = 11'd1024;
  localparam logic [HueW-1:0] HueOffReset  = 11'd768;

  // Divider: stages and quotient bits resolved per stage
  localparam int unsigned DivStages    = 3;
  localparam int unsigned DivBitsStage = QuotW / DivStages;

  typedef enum logic [2:0] {
    SextRedUp     = 3'd0,
    SextGreenDown = 3'd1,
    SextGreenUp   = 3'd2,
    SextBlueDown  = 3'd3,
    SextBlueUp    = 3'd4,
    SextRedDown   = 3'd5
  } sext_e;

  typedef struct packed {
    logic [PixW-1:0] blue_in;
    logic [PixW-1:0] green_in;
    logic [PixW-1:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] blue_out;
    logic [PixW-1:0] green_out;
    logic [PixW-1:0] red_out;
  } pix_out_t;

  // Per-pixel data that rides alongside the divider
  typedef struct packed {
    logic [PixW-1:0] mx;
    logic [PixW-1:0] mn;
    logic [PixW-1:0] delta;
    logic [HueW-1:0] base;
    logic            neg;
  } hue_side_t;

  typedef struct packed {
    logic [PixW-1:0] num;
    logic [PixW-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             rem_nz;
  } div_out_t;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [PixW:0] div_step(logic [PixW-1:0] rem, logic [PixW-1:0] den);
    logic [PixW:0] t;
    logic [PixW:0] d;
    t = {rem, 1'b0};
    d = {1'b0, den};
    if (t >= d) begin
      div_step = {1'b1, t[PixW-1:0] - den};
    end else begin
      div_step = {1'b0, t[PixW-1:0]};
    end
  endfunction

endpackage

// File: rtl/hsvrot_div.sv
// Pipelined restoring divider: floor(num * 256 / den), three quotient bits per stage.
module hsvrot_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  hsvrot_pkg::div_in_t   op_i,
  input  hsvrot_pkg::hue_side_t side_i,
  output logic                  valid_o,
  output logic                  pending_o,
  output hsvrot_pkg::div_out_t  res_o,
  output hsvrot_pkg::hue_side_t side_o
);

  localparam int unsigned N = hsvrot_pkg::DivStages;
  localparam int unsigned B = hsvrot_pkg::DivBitsStage;
  localparam int unsigned W = hsvrot_pkg::PixW;
  localparam int unsigned Q = hsvrot_pkg::QuotW;

  logic                  valid_q [N];
  logic [W-1:0]          rem_q   [N];
  logic [W-1:0]          rem_d   [N];
  logic [Q-1:0]          quot_q  [N];
  logic [Q-1:0]          quot_d  [N];
  logic [W-1:0]          den_q   [N];
  hsvrot_pkg::hue_side_t side_q  [N];

  always_comb begin
    logic [W-1:0] r;
    logic [Q-1:0] q;
    logic [W:0]   st;
    // leading bit: num compared unshifted, since num <= den
    q = '0;
    if (op_i.num >= op_i.den) begin
      q[0] = 1'b1;
      r    = op_i.num - op_i.den;
    end else begin
      r    = op_i.num;
    end
    for (int k = 1; k < B; k++) begin
      st = hsvrot_pkg::div_step(r, op_i.den);
      q  = {q[Q-2:0], st[W]};
      r  = st[W-1:0];
    end
    rem_d[0]  = r;
    quot_d[0] = q;
    for (int s = 1; s < N; s++) begin
      q = quot_q[s-1];
      r = rem_q[s-1];
      for (int k = 0; k < B; k++) begin
        st = hsvrot_pkg::div_step(r, den_q[s-1]);
        q  = {q[Q-2:0], st[W]};
        r  = st[W-1:0];
      end
      rem_d[s]  = r;
      quot_d[s] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < N; s++) valid_q[s] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < N; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rem_d[0];
    quot_q[0] <= quot_d[0];
    den_q[0]  <= op_i.den;
    side_q[0] <= side_i;
    for (int s = 1; s < N; s++) begin
      rem_q[s]  <= rem_d[s];
      quot_q[s] <= quot_d[s];
      den_q[s]  <= den_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  // any stage still holding a transfer
  always_comb begin
    pending_o = 1'b0;
    for (int s = 0; s < N; s++) pending_o = pending_o | valid_q[s];
  end

  assign valid_o      = valid_q[N-1];
  assign res_o.quot   = quot_q[N-1];
  assign res_o.rem_nz = |rem_q[N-1];
  assign side_o       = side_q[N-1];

  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##3 valid_o)
    else $error("divider lost a transfer");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && side_o.delta != '0) |-> res_o.quot <= 9'd256)
    else $error("quotient above one sextant");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && side_o.delta != '0) |-> rem_q[N-1] < den_q[N-1])
    else $error("remainder not below divisor");

endmodule

// File: rtl/hsv_hue_rotate_pixel.sv
// Top level: RGB pixel hue rotation through an integer HSV pipeline.
//
// One pixel is taken per clock: start with busy low is a transfer, and busy
// never rises, so pixels may be issued back to back without a gap. Each
// result appears on pixel_o for a single cycle, flagged by out_valid_o;
// the receiver cannot stall the output, so it must take every result as it
// comes. The pipeline has one stage for min/max and channel difference,
// three stages of the hue divider (three quotient bits each), one for hue
// and offset wrap, one for the two ramp multipliers and one for the output
// register. Grey and black pixels pass through unchanged. The hue offset is
// written on the cfg channel, taken modulo 1536 (one full turn) at write
// time, and cfg_ready_o is low while start is high or any pixel is in
// flight.
module hsv_hue_rotate_pixel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  hsvrot_pkg::pix_in_t  pixel_i,
  output logic                 out_valid_o,
  output hsvrot_pkg::pix_out_t pixel_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [10:0]          cfg_data_i
);

  localparam int unsigned W = hsvrot_pkg::PixW;
  localparam int unsigned H = hsvrot_pkg::HueW;

  logic take;

  // Hue offset register, held already reduced below one turn
  logic [H-1:0] hue_off_q;

  // Stage 1: extremes and hue numerator
  logic                  s1_valid_q;
  hsvrot_pkg::hue_side_t s1_side_q, s1_side_d;
  logic [W-1:0]          s1_num_q, s1_num_d;

  // Divider outputs
  logic                  dv_valid;
  logic                  dv_busy;
  hsvrot_pkg::div_out_t  dv_res;
  hsvrot_pkg::hue_side_t dv_side;
  hsvrot_pkg::div_in_t   dv_op;

  // Stage 5: hue after rotation
  logic         s5_valid_q;
  logic [H-1:0] s5_hue_q, s5_hue_d;
  logic [W-1:0] s5_mx_q, s5_mn_q, s5_delta_q;

  // Stage 6: ramps
  logic         s6_valid_q;
  logic [2:0]   s6_sext_q;
  logic [W-1:0] s6_up_q, s6_down_q, s6_mx_q, s6_mn_q;
  logic [W-1:0] s6_up_d, s6_down_d;

  // Stage 7: output
  logic                 s7_valid_q;
  hsvrot_pkg::pix_out_t s7_pix_q, s7_pix_d;

  assign busy        = 1'b0;
  assign take        = start && !busy;
  // offset only changes with the whole pipe empty and no pixel on offer
  assign cfg_ready_o = !(start || s1_valid_q || dv_busy || s5_valid_q || s6_valid_q ||
                         s7_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q <= hsvrot_pkg::HueOffReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i >= hsvrot_pkg::HueTurn) begin
        hue_off_q <= cfg_data_i - hsvrot_pkg::HueTurn;
      end else begin
        hue_off_q <= cfg_data_i;
      end
    end
  end

  // ---- stage 1 ----
  always_comb begin
    logic [W-1:0] r, g, b, mx, mn;
    logic [W:0]   diff;
    r  = pixel_i.red_in;
    g  = pixel_i.green_in;
    b  = pixel_i.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // sector picked by which channel is largest, red first
    if (r == mx) begin
      diff           = {1'b0, g} - {1'b0, b};
      s1_side_d.base = diff[W] ? hsvrot_pkg::HueTurn : hsvrot_pkg::HueBaseRed;
    end else if (g == mx) begin
      diff           = {1'b0, b} - {1'b0, r};
      s1_side_d.base = hsvrot_pkg::HueBaseGreen;
    end else begin
      diff           = {1'b0, r} - {1'b0, g};
      s1_side_d.base = hsvrot_pkg::HueBaseBlue;
    end
    s1_side_d.mx    = mx;
    s1_side_d.mn    = mn;
    s1_side_d.delta = mx - mn;
    s1_side_d.neg   = diff[W];
    s1_num_d        = diff[W] ? W'(-diff) : diff[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= s1_side_d;
    s1_num_q  <= s1_num_d;
  end

  assign dv_op.num = s1_num_q;
  assign dv_op.den = s1_side_q.delta;

  hsvrot_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .op_i      (dv_op),
    .side_i    (s1_side_q),
    .valid_o   (dv_valid),
    .pending_o (dv_busy),
    .res_o     (dv_res),
    .side_o    (dv_side)
  );

  // ---- stage 5: signed floor quotient, base, offset, wrap ----
  always_comb begin
    logic [H-1:0] mag, raw;
    logic [H:0]   sum;
    mag = H'(dv_res.quot);
    // floor of a negative ratio rounds away from zero
    if (dv_side.neg) begin
      mag = mag + H'(dv_res.rem_nz);
      raw = dv_side.base - mag;
    end else begin
      raw = dv_side.base + mag;
    end
    sum = {1'b0, raw} + {1'b0, hue_off_q};
    if (sum >= {1'b0, hsvrot_pkg::HueTurn}) begin
      sum = sum - {1'b0, hsvrot_pkg::HueTurn};
    end
    s5_hue_d = sum[H-1:0];
  end

  always_ff @(posedge clk_i) begin
    s5_hue_q   <= s5_hue_d;
    s5_mx_q    <= dv_side.mx;
    s5_mn_q    <= dv_side.mn;
    s5_delta_q <= dv_side.delta;
  end

  // ---- stage 6: ramp multipliers ----
  always_comb begin
    logic [2*W-1:0] p_up;
    logic [2*W:0]   p_down;
    logic [W:0]     inv;
    inv       = (W+1)'(1 << W) - {1'b0, s5_hue_q[W-1:0]};
    p_up      = s5_hue_q[W-1:0] * s5_delta_q;
    p_down    = inv * s5_delta_q;
    s6_up_d   = p_up[2*W-1:W];
    s6_down_d = p_down[2*W-1:W];
  end

  always_ff @(posedge clk_i) begin
    s6_sext_q <= s5_hue_q[H-1:W];
    s6_up_q   <= s6_up_d;
    s6_down_q <= s6_down_d;
    s6_mx_q   <= s5_mx_q;
    s6_mn_q   <= s5_mn_q;
  end

  // ---- stage 7: rebuild by sextant ----
  always_comb begin
    logic [W-1:0] up, down;
    up   = s6_mn_q + s6_up_q;
    down = s6_mn_q + s6_down_q;
    case (hsvrot_pkg::sext_e'(s6_sext_q))
      hsvrot_pkg::SextRedUp: begin
        s7_pix_d = '{blue_out: s6_mn_q, green_out: up, red_out: s6_mx_q};
      end
      hsvrot_pkg::SextGreenDown: begin
        s7_pix_d = '{blue_out: s6_mn_q, green_out: s6_mx_q, red_out: down};
      end
      hsvrot_pkg::SextGreenUp: begin
        s7_pix_d = '{blue_out: up, green_out: s6_mx_q, red_out: s6_mn_q};
      end
      hsvrot_pkg::SextBlueDown: begin
        s7_pix_d = '{blue_out: s6_mx_q, green_out: down, red_out: s6_mn_q};
      end
      hsvrot_pkg::SextBlueUp: begin
        s7_pix_d = '{blue_out: s6_mx_q, green_out: s6_mn_q, red_out: up};
      end
      default: begin
        s7_pix_d = '{blue_out: down, green_out: s6_mn_q, red_out: s6_mx_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s7_pix_q <= s7_pix_d;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take;
      s5_valid_q <= dv_valid;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
    end
  end

  assign out_valid_o = s7_valid_q;
  assign pixel_o     = s7_pix_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##7 out_valid_o)
    else $error("pixel transfer did not yield a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(take, 7))
    else $error("result without a pixel transfer");

  a_ramp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_valid_q |-> (s6_up_q <= s6_mx_q - s6_mn_q && s6_down_q <= s6_mx_q - s6_mn_q))
    else $error("ramp exceeds channel spread");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q |-> s5_hue_q < hsvrot_pkg::HueTurn)
    else $error("rotated hue beyond one turn");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> hue_off_q < hsvrot_pkg::HueTurn)
    else $error("hue offset not reduced on write");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the HSV hue rotation pixel pipeline.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog limit, far above the slowest legal run, for plenty of headroom
  localparam int CycleLimit = 400000;
  // Extra wait at the end, longer than the start-to-result latency
  localparam int TailCycles = 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  hsvrot_pkg::pix_in_t  pixel_i;
  logic                 out_valid_o;
  hsvrot_pkg::pix_out_t pixel_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [10:0]          cfg_data_i;

  hsv_hue_rotate_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .pixel_o     (pixel_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Our copy of the offset register and the pixels still owed by the DUT
  logic [hsvrot_pkg::HueW-1:0] hue_off_model;
  hsvrot_pkg::pix_out_t        rotated_q[$];

  int n_pixels;
  int n_checked;
  int n_errors;
  int n_cfg_writes;
  int n_grey;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Division rounding towards minus infinity, d > 0
  function automatic int floor_quot(int n, int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // RGB -> hue (1/256 sextant units) -> add offset mod one turn -> RGB.
  // Max and min channel are kept, so value and spread survive exactly.
  function automatic hsvrot_pkg::pix_out_t rotate_hue(hsvrot_pkg::pix_in_t px,
                                                      logic [hsvrot_pkg::HueW-1:0] off);
    int r, g, b, mx, mn, dl, hue, fr, up, dn;
    hsvrot_pkg::sext_e sx;
    hsvrot_pkg::pix_out_t res;
    r  = px.red_in;
    g  = px.green_in;
    b  = px.blue_in;
    mx = (r > g) ? r : g;
    mx = (b > mx) ? b : mx;
    mn = (r < g) ? r : g;
    mn = (b < mn) ? b : mn;
    dl = mx - mn;
    res.red_out   = px.red_in;
    res.green_out = px.green_in;
    res.blue_out  = px.blue_in;
    // grey and black have no hue: pass straight through
    if (dl == 0) return res;
    // ties on the max go to red first, then green
    if (r == mx) begin
      hue = int'(hsvrot_pkg::HueBaseRed) + floor_quot(256 * (g - b), dl);
      if (hue < 0) hue += int'(hsvrot_pkg::HueTurn);
    end else if (g == mx) begin
      hue = int'(hsvrot_pkg::HueBaseGreen) + floor_quot(256 * (b - r), dl);
    end else begin
      hue = int'(hsvrot_pkg::HueBaseBlue) + floor_quot(256 * (r - g), dl);
    end
    // offsets past a full turn wrap
    hue += int'(off) % int'(hsvrot_pkg::HueTurn);
    if (hue >= int'(hsvrot_pkg::HueTurn)) hue -= int'(hsvrot_pkg::HueTurn);
    sx = hsvrot_pkg::sext_e'(3'(hue >> 8));
    fr = hue & 255;
    up = (fr * dl) >> 8;
    dn = ((256 - fr) * dl) >> 8;
    case (sx)
      hsvrot_pkg::SextRedUp: begin
        res.red_out = 8'(mx); res.green_out = 8'(mn + up); res.blue_out = 8'(mn);
      end
      hsvrot_pkg::SextGreenDown: begin
        res.red_out = 8'(mn + dn); res.green_out = 8'(mx); res.blue_out = 8'(mn);
      end
      hsvrot_pkg::SextGreenUp: begin
        res.red_out = 8'(mn); res.green_out = 8'(mx); res.blue_out = 8'(mn + up);
      end
      hsvrot_pkg::SextBlueDown: begin
        res.red_out = 8'(mn); res.green_out = 8'(mn + dn); res.blue_out = 8'(mx);
      end
      hsvrot_pkg::SextBlueUp: begin
        res.red_out = 8'(mn + up); res.green_out = 8'(mn); res.blue_out = 8'(mx);
      end
      default: begin
        res.red_out = 8'(mx); res.green_out = 8'(mn); res.blue_out = 8'(mn + dn);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly back to back, some short gaps, the odd long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Skews towards the awkward pixels: greys, tied channels, rail values
  function automatic hsvrot_pkg::pix_in_t random_pixel();
    hsvrot_pkg::pix_in_t px;
    int kind;
    kind = $urandom_range(0, 9);
    px.red_in   = 8'($urandom);
    px.green_in = 8'($urandom);
    px.blue_in  = 8'($urandom);
    case (kind)
      0: begin
        px.green_in = px.red_in;
        px.blue_in  = px.red_in;
      end
      1: begin
        // two channels are made equal, not always at the maximum
        case ($urandom_range(0, 2))
          0: px.green_in = px.red_in;
          1: px.blue_in  = px.green_in;
          default: px.red_in = px.blue_in;
        endcase
      end
      2: begin
        px.red_in  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.blue_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Idle the sender; drops start only when there really is a gap
  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // One pixel transfer. Start is left high so the next call can follow
  // without a bubble; idle_for/drain_results take it low.
  task automatic push_pixel(hsvrot_pkg::pix_in_t px);
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy);
    rotated_q.push_back(rotate_hue(px, hue_off_model));
    n_pixels++;
    if (px.red_in == px.green_in && px.green_in == px.blue_in) n_grey++;
  endtask

  task automatic push_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsvrot_pkg::pix_in_t px;
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    push_pixel(px);
  endtask

  // Hold the sender off until every outstanding pixel has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (rotated_q.size() != 0);
  endtask

  // Offset write, only ever done with the pipe empty
  task automatic write_hue_offset(logic [10:0] off);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= off;
    do @(posedge clk_i); while (!cfg_ready_o);
    hue_off_model = off;
    n_cfg_writes++;
    cfg_valid_i <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Primaries, secondaries, rails, grey and black under the reset offset
  task automatic test_reset_offset();
    push_rgb(8'd0,   8'd0,   8'd0);
    push_rgb(8'd255, 8'd255, 8'd255);
    push_rgb(8'd128, 8'd128, 8'd128);
    push_rgb(8'd255, 8'd0,   8'd0);
    push_rgb(8'd0,   8'd255, 8'd0);
    push_rgb(8'd0,   8'd0,   8'd255);
    idle_for(2);
    push_rgb(8'd255, 8'd255, 8'd0);
    push_rgb(8'd0,   8'd255, 8'd255);
    push_rgb(8'd255, 8'd0,   8'd255);
    // red max with blue above green: hue goes negative and wraps
    push_rgb(8'd255, 8'd0,   8'd1);
    push_rgb(8'd255, 8'd1,   8'd0);
    idle_for(5);
    push_rgb(8'd1,   8'd0,   8'd0);
    push_rgb(8'd0,   8'd1,   8'd1);
    push_rgb(8'd254, 8'd255, 8'd255);
    push_rgb(8'd10,  8'd200, 8'd90);
    push_rgb(8'd170, 8'd85,  8'd0);
    push_rgb(8'd1,   8'd2,   8'd3);
    push_rgb(8'd85,  8'd170, 8'd255);
  endtask

  // Offset corners, including values that must wrap past a full turn
  task automatic test_offset_extremes();
    logic [10:0] offs[6];
    offs = '{11'd0, 11'd1, 11'd1535, 11'd1536, 11'd2047, 11'd1024};
    foreach (offs[i]) begin
      write_hue_offset(offs[i]);
      push_rgb(8'd255, 8'd0,   8'd0);
      push_rgb(8'd0,   8'd255, 8'd0);
      push_rgb(8'd0,   8'd0,   8'd255);
      push_rgb(8'd255, 8'd128, 8'd0);
      push_rgb(8'd0,   8'd0,   8'd0);
      repeat (20) begin
        push_pixel(random_pixel());
        idle_for(gap_len());
      end
    end
  endtask

  // Full-rate stream, then a hold until the pipe has emptied
  task automatic test_back_to_back();
    write_hue_offset(11'($urandom_range(0, 2047)));
    repeat (150) push_pixel(random_pixel());
    drain_results();
  endtask

  // Random offsets and pixels with random gaps; one mid-phase hold-off
  task automatic test_random_stream();
    for (int ph = 0; ph < 8; ph++) begin
      write_hue_offset(11'($urandom_range(0, 2047)));
      for (int i = 0; i < 50; i++) begin
        if (i == 25) drain_results();
        push_pixel(random_pixel());
        idle_for(gap_len());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checking: every out_valid_o pulse must match the oldest
  // prediction, field by field
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    hsvrot_pkg::pix_out_t want;
    if (rst_ni && out_valid_o) begin
      if (rotated_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing outstanding: r=%0d g=%0d b=%0d", $time,
                 pixel_o.red_out, pixel_o.green_out, pixel_o.blue_out);
      end else begin
        want = rotated_q.pop_front();
        n_checked++;
        if (pixel_o.red_out !== want.red_out) begin
          n_errors++;
          $display("%0t: red mismatch: expected %0d, got %0d", $time,
                   want.red_out, pixel_o.red_out);
        end
        if (pixel_o.green_out !== want.green_out) begin
          n_errors++;
          $display("%0t: green mismatch: expected %0d, got %0d", $time,
                   want.green_out, pixel_o.green_out);
        end
        if (pixel_o.blue_out !== want.blue_out) begin
          n_errors++;
          $display("%0t: blue mismatch: expected %0d, got %0d", $time,
                   want.blue_out, pixel_o.blue_out);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time, rotated_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    pixel_i       = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    hue_off_model = hsvrot_pkg::HueOffReset;
    n_pixels      = 0;
    n_checked     = 0;
    n_errors      = 0;
    n_cfg_writes  = 0;
    n_grey        = 0;
    cycles        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_offset();
    test_offset_extremes();
    test_back_to_back();
    test_random_stream();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (rotated_q.size() != 0) begin
      n_errors += rotated_q.size();
      $display("%0t: %0d results never arrived", $time, rotated_q.size());
    end

    $display("Rotated %0d pixels (%0d grey or black), %0d results checked,",
             n_pixels, n_grey, n_checked);
    $display("across %0d offset writes incl. 0, 1535 and wrapping values.", n_cfg_writes);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: hsv_hue_rotate_pixel.f
rtl/hsvrot_pkg.sv
rtl/hsvrot_div.sv
rtl/hsv_hue_rotate_pixel.sv
tb/sv/tb.sv
